>>> hdl/sbb_pkg.sv
// shared types, constants and helpers for the spectrum bar ballistics unit
`default_nettype none

package sbb_pkg;

    // fixed field widths
    localparam int BAR_W  = 7;
    localparam int IN_W   = 32;
    localparam int OUT_W  = 32;
    localparam int GAIN_W = 17;
    localparam int HOLD_W = 10;

    // parameter defaults
    localparam int BAR_TOTAL_DEF  = 128;
    localparam int POWER_BITS_DEF = 32;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(65536);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd3;

    localparam logic [GAIN_W-1:0] ATTACK_RST  = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0] RELEASE_RST = GAIN_W'(4096);
    localparam logic [HOLD_W-1:0] HOLD_RST    = HOLD_W'(30);
    localparam logic [GAIN_W-1:0] DECAY_RST   = GAIN_W'(62000);

    // item kinds
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0] attack;
        logic [GAIN_W-1:0] release_g;
        logic [HOLD_W-1:0] hold;
        logic [GAIN_W-1:0] decay;
    } t_cfg;

    // queue head seen by the back part
    typedef struct packed {
        logic valid;
        logic kind;
        logic in_range;
    } t_head;

    // back part status seen by the front part
    typedef struct packed {
        logic pop;
        logic busy;
    } t_back_stat;

    function automatic logic [GAIN_W-1:0] sat_gain(input logic [GAIN_W-1:0] g);
        return (g > UNITY) ? UNITY : g;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sbb_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module sbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> hdl/sbb_front.sv
// front part: accepts items, classifies them and queues them for the back part
`default_nettype none

module sbb_front
    import sbb_pkg::*;
#(
    parameter int BAR_TOTAL  = BAR_TOTAL_DEF,
    parameter int POWER_BITS = POWER_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_kind,
    input  wire logic [BAR_W-1:0]      i_bar_index,
    input  wire logic [IN_W-1:0]       i_target_power,
    input  wire t_back_stat            i_stat,
    output t_head                      o_head,
    output logic      [BAR_W-1:0]      o_head_bar,
    output logic      [POWER_BITS-1:0] o_head_target
);

    localparam int PB    = POWER_BITS;
    localparam int CMP_W = ($clog2(BAR_TOTAL + 1) > BAR_W) ? $clog2(BAR_TOTAL + 1) : BAR_W;

    logic [BAR_W-1:0]  r_q_bar    [QUEUE_DEPTH];
    logic              r_q_kind   [QUEUE_DEPTH];
    logic              r_q_inr    [QUEUE_DEPTH];
    logic [PB-1:0]     r_q_target [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;

    logic              push;
    logic              in_range;
    logic [PB+IN_W-1:0] target_ext;

    assign in_range   = CMP_W'(i_bar_index) < CMP_W'(BAR_TOTAL);
    assign target_ext = {{PB{1'b0}}, i_target_power};

    assign o_in_stall = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH)) || i_stat.busy;
    assign push       = i_in_valid && !o_in_stall;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_stat.pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !i_stat.pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_stat.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_bar[r_wr_ptr]    <= i_bar_index;
            r_q_kind[r_wr_ptr]   <= i_kind;
            r_q_inr[r_wr_ptr]    <= in_range;
            r_q_target[r_wr_ptr] <= target_ext[PB-1:0];
        end
    end

    assign o_head.valid    = (r_count != '0);
    assign o_head.kind     = r_q_kind[r_rd_ptr];
    assign o_head.in_range = r_q_inr[r_rd_ptr];
    assign o_head_bar      = r_q_bar[r_rd_ptr];
    assign o_head_target   = r_q_target[r_rd_ptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.pop |-> (r_count != '0))
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_stat.pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a transfer");

endmodule

`default_nettype wire

>>> hdl/sbb_back.sv
// back part: per-bar state ram, smoothing, peak hold and maximum pipeline
`default_nettype none

module sbb_back
    import sbb_pkg::*;
#(
    parameter int BAR_TOTAL  = BAR_TOTAL_DEF,
    parameter int POWER_BITS = POWER_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_head                 i_head,
    input  wire logic [BAR_W-1:0]      i_head_bar,
    input  wire logic [POWER_BITS-1:0] i_head_target,
    output t_back_stat                 o_stat,
    input  wire t_cfg                  i_cfg,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [BAR_W-1:0]      o_out_bar,
    output logic      [OUT_W-1:0]      o_smoothed_level,
    output logic      [OUT_W-1:0]      o_peak_out,
    output logic      [OUT_W-1:0]      o_max_out
);

    localparam int PB  = POWER_BITS;
    localparam int IW  = $clog2(BAR_TOTAL);
    localparam int WW  = 3 * PB + HOLD_W;
    localparam int MW  = PB + GAIN_W;

    // init sweep
    logic          r_init;
    logic [IW-1:0] r_sweep;

    // stage 1: ram data arrives
    logic          r_s1_valid;
    logic          r_s1_kind;
    logic          r_s1_inr;
    logic [IW-1:0] r_s1_idx;
    logic [BAR_W-1:0] r_s1_bar;
    logic [PB-1:0] r_s1_target;

    // stage 2: products ready
    logic          r_s2_valid;
    logic          r_s2_kind;
    logic          r_s2_inr;
    logic [IW-1:0] r_s2_idx;
    logic [BAR_W-1:0] r_s2_bar;
    logic          r_s2_rise;
    logic [PB-1:0] r_s2_y;
    logic [PB-1:0] r_s2_p;
    logic [HOLD_W-1:0] r_s2_h;
    logic [PB-1:0] r_s2_m;
    logic [MW-1:0] r_s2_prod_s;
    logic [MW-1:0] r_s2_prod_d;

    // output register
    logic             r_out_valid;
    logic [BAR_W-1:0] r_out_bar;
    logic [OUT_W-1:0] r_out_y;
    logic [OUT_W-1:0] r_out_p;
    logic [OUT_W-1:0] r_out_m;

    logic              adv;
    logic              hazard;
    logic              pop;
    logic [IW+BAR_W-1:0] head_ext;
    logic [IW-1:0]     head_idx;

    logic [WW-1:0]     rd_word;
    logic [PB-1:0]     s1_y, s1_p, s1_m;
    logic [HOLD_W-1:0] s1_h;
    logic              s1_rise;
    logic [PB-1:0]     s1_diff;
    logic [GAIN_W-1:0] s1_gain;
    logic [MW-1:0]     n_prod_s, n_prod_d;

    logic [PB-1:0]     step, decayed;
    logic [PB-1:0]     y_new, p_new, m_new;
    logic [HOLD_W-1:0] h_new;
    logic [WW-1:0]     wr_word;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [WW-1:0]     wr_data;
    logic [PB+OUT_W-1:0] y_ext, p_ext, m_ext;

    assign head_ext = {{IW{1'b0}}, i_head_bar};
    assign head_idx = head_ext[IW-1:0];

    assign adv    = !r_out_valid || !i_out_stall;
    // same bar still in flight: wait until its state is written back
    assign hazard = (r_s1_valid && r_s1_inr && (r_s1_idx == head_idx))
                 || (r_s2_valid && r_s2_inr && (r_s2_idx == head_idx));
    assign pop    = i_head.valid && adv && !hazard && !r_init;

    assign o_stat.pop  = pop;
    assign o_stat.busy = r_init;

    sbb_ram #(
        .WIDTH (WW),
        .DEPTH (BAR_TOTAL)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (pop),
        .i_rd_addr (head_idx),
        .o_rd_data (rd_word)
    );

    // word layout: max, peak, hold count, smoothed
    assign s1_y = rd_word[PB-1:0];
    assign s1_h = rd_word[PB+HOLD_W-1:PB];
    assign s1_p = rd_word[2*PB+HOLD_W-1:PB+HOLD_W];
    assign s1_m = rd_word[WW-1:2*PB+HOLD_W];

    assign s1_rise  = r_s1_target > s1_y;
    assign s1_diff  = s1_rise ? (r_s1_target - s1_y) : (s1_y - r_s1_target);
    assign s1_gain  = s1_rise ? i_cfg.attack : i_cfg.release_g;
    assign n_prod_s = {{PB{1'b0}}, s1_gain} * {{GAIN_W{1'b0}}, s1_diff};
    assign n_prod_d = {{PB{1'b0}}, i_cfg.decay} * {{GAIN_W{1'b0}}, s1_p};

    always_comb begin
        step    = r_s2_prod_s[PB+15:16];
        decayed = r_s2_prod_d[PB+15:16];
        y_new   = r_s2_y;
        p_new   = r_s2_p;
        h_new   = r_s2_h;
        m_new   = r_s2_m;
        if (r_s2_kind == KIND_CLEAR) begin
            p_new = '0;
            h_new = '0;
            m_new = '0;
        end else begin
            y_new = r_s2_rise ? (r_s2_y + step) : (r_s2_y - step);
            if (y_new > r_s2_p) begin
                p_new = y_new;
                h_new = i_cfg.hold;
            end else if (r_s2_h != '0) begin
                h_new = r_s2_h - 1'b1;
            end else begin
                // hold expired: decay, floored at the smoothed level
                p_new = (decayed < y_new) ? y_new : decayed;
            end
            if (y_new > r_s2_m) begin
                m_new = y_new;
            end
        end
        wr_word = {m_new, p_new, h_new, y_new};
    end

    assign wr_en   = r_init || (adv && r_s2_valid && r_s2_inr);
    assign wr_addr = r_init ? r_sweep : r_s2_idx;
    assign wr_data = r_init ? '0 : wr_word;

    assign y_ext = {{OUT_W{1'b0}}, y_new};
    assign p_ext = {{OUT_W{1'b0}}, p_new};
    assign m_ext = {{OUT_W{1'b0}}, m_new};

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= 1'b1;
            r_sweep     <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_init) begin
                r_sweep <= r_sweep + 1'b1;
                if (r_sweep == IW'(BAR_TOTAL - 1)) begin
                    r_init <= 1'b0;
                end
            end
            if (adv) begin
                r_s1_valid  <= pop;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_kind   <= i_head.kind;
            r_s1_inr    <= i_head.in_range;
            r_s1_idx    <= head_idx;
            r_s1_bar    <= i_head_bar;
            r_s1_target <= i_head_target;

            r_s2_kind   <= r_s1_kind;
            r_s2_inr    <= r_s1_inr;
            r_s2_idx    <= r_s1_idx;
            r_s2_bar    <= r_s1_bar;
            r_s2_rise   <= s1_rise;
            r_s2_y      <= s1_y;
            r_s2_p      <= s1_p;
            r_s2_h      <= s1_h;
            r_s2_m      <= s1_m;
            r_s2_prod_s <= n_prod_s;
            r_s2_prod_d <= n_prod_d;

            r_out_bar   <= r_s2_bar;
            r_out_y     <= r_s2_inr ? y_ext[OUT_W-1:0] : '0;
            r_out_p     <= r_s2_inr ? p_ext[OUT_W-1:0] : '0;
            r_out_m     <= r_s2_inr ? m_ext[OUT_W-1:0] : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_bar        = r_out_bar;
    assign o_smoothed_level = r_out_y;
    assign o_peak_out       = r_out_p;
    assign o_max_out        = r_out_m;

    a_no_pop_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !pop)
        else $error("item issued during init sweep");

    a_no_same_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s2_valid && r_s1_inr && r_s2_inr) |-> (r_s1_idx != r_s2_idx))
        else $error("two updates of one bar in flight");

    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_s2_valid) && $stable(r_s1_valid)))
        else $error("pipeline moved while frozen");

    a_peak_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_inr && (r_s2_kind == KIND_UPDATE)) |-> (p_new >= y_new))
        else $error("peak below smoothed level");

endmodule

`default_nettype wire

>>> hdl/spectrum_bar_ballistics_unit.sv
// top level of the spectrum bar ballistics unit: config registers, front and back parts
//
// channel   direction  handshake                         payload
// input     in         i_in_valid / o_in_stall           i_kind, i_bar_index, i_target_power
// output    out        o_out_valid / i_out_stall         o_out_bar, o_smoothed_level,
//                                                        o_peak_out, o_max_out
// config    in         i_cfg_valid / o_cfg_ready         i_cfg_index, i_cfg_data
//
// one item per cycle while the output is not stalled and each item names a bar other
// than the two before it; an item for the same bar as one of the two before it waits
// for the state ram read-modify-write (registered ram read, then multiply stage, then
// write back). a 4-entry queue decouples input from output stalls. after reset a
// clearing pass zeroes each of the BAR_TOTAL ram entries, with o_in_stall high;
// config writes are taken at any time.
`default_nettype none

module spectrum_bar_ballistics_unit
    import sbb_pkg::*;
#(
    parameter int BAR_TOTAL  = BAR_TOTAL_DEF,
    parameter int POWER_BITS = POWER_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_kind,
    input  wire logic [BAR_W-1:0]     i_bar_index,
    input  wire logic [IN_W-1:0]      i_target_power,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [BAR_W-1:0]     o_out_bar,
    output logic      [OUT_W-1:0]     o_smoothed_level,
    output logic      [OUT_W-1:0]     o_peak_out,
    output logic      [OUT_W-1:0]     o_max_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [GAIN_W-1:0]    i_cfg_data
);

    t_cfg       r_cfg, n_cfg;
    t_head      head;
    t_back_stat stat;
    logic [BAR_W-1:0]      head_bar;
    logic [POWER_BITS-1:0] head_target;

    assign o_cfg_ready = 1'b1;

    // gains are kept already saturated to unity
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ATTACK:  n_cfg.attack    = sat_gain(i_cfg_data);
                CFG_RELEASE: n_cfg.release_g = sat_gain(i_cfg_data);
                CFG_HOLD:    n_cfg.hold      = i_cfg_data[HOLD_W-1:0];
                CFG_DECAY:   n_cfg.decay     = sat_gain(i_cfg_data);
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack    <= ATTACK_RST;
            r_cfg.release_g <= RELEASE_RST;
            r_cfg.hold      <= HOLD_RST;
            r_cfg.decay     <= DECAY_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    sbb_front #(
        .BAR_TOTAL  (BAR_TOTAL),
        .POWER_BITS (POWER_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_bar_index    (i_bar_index),
        .i_target_power (i_target_power),
        .i_stat         (stat),
        .o_head         (head),
        .o_head_bar     (head_bar),
        .o_head_target  (head_target)
    );

    sbb_back #(
        .BAR_TOTAL  (BAR_TOTAL),
        .POWER_BITS (POWER_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .i_head_bar       (head_bar),
        .i_head_target    (head_target),
        .o_stat           (stat),
        .i_cfg            (r_cfg),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_bar        (o_out_bar),
        .o_smoothed_level (o_smoothed_level),
        .o_peak_out       (o_peak_out),
        .o_max_out        (o_max_out)
    );

endmodule

`default_nettype wire
